/* hw/rtl/sobel_edge_magnitude_threshold_defines.svh */
// Assertion macros shared by the Sobel edge block.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef SOBEL_EDGE_MAGNITUDE_THRESHOLD_DEFINES_SVH
`define SOBEL_EDGE_MAGNITUDE_THRESHOLD_DEFINES_SVH

// same-cycle implication
`define SEMT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SEMT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/semt_pkg.sv */
// Shared types and constants for the Sobel edge block.
// No dependencies.
`timescale 1ns / 1ps

package semt_pkg;

	localparam int PIX_W    = 8;
	localparam int ROW_W    = 16;
	localparam int CFG_W    = 16;
	localparam int WIDTH_W  = 12;
	localparam int HEIGHT_W = 16;
	localparam int THRESH_W = 8;
	localparam int GRAD_W   = 11;
	localparam int SQ_W     = 21;
	localparam int RAD_W    = 16;
	localparam int REM_W    = 10;

	localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 12'd640;
	localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 16'd480;
	localparam logic [THRESH_W-1:0] THRESH_RST = 8'd50;

	localparam logic [0:0] OP_PIXEL = 1'b0;
	localparam logic [0:0] OP_FLUSH = 1'b1;

	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_THRESH = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD,
		ST_GRAD,
		ST_SQ,
		ST_ROOT,
		ST_OUT
	} state_t;

endpackage

/* hw/rtl/sobel_edge_magnitude_threshold.sv */
// Sobel 3x3 edge detector: row stores in RAM, window, gradient, root, threshold.
// A pixel item with a result passes the row-read, gradient, square, root and output
// states in that order; a flush item with a result starts at the gradient state.
// A new item is taken only in the idle state, after the last one has left the output
// state, where a waiting result can hold the block. A pixel without a result goes back
// to idle after the row read; the square root is bit-serial, in 8 steps.
// Reset (arst_n, async): counters, window, state and valid cleared, config to defaults.
// Depends on semt_pkg, semt_ram and sobel_edge_magnitude_threshold_defines.svh.
`timescale 1ns / 1ps
`include "sobel_edge_magnitude_threshold_defines.svh"

module sobel_edge_magnitude_threshold #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [15:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] pixel
	input  logic [0:0]  s_axis_tuser,   // [0] op
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [7:0] magnitude, [8] edge_res, [15:9] zero
	output logic        m_axis_tlast    // frame_last
);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int PW = $clog2(MAX_WIDTH + 2);
	localparam int CW = (WW > semt_pkg::WIDTH_W) ? WW : semt_pkg::WIDTH_W;
	localparam int RW = semt_pkg::ROW_W;
	localparam int PX = semt_pkg::PIX_W;

	semt_pkg::state_t state_q, state_d;

	logic [semt_pkg::WIDTH_W-1:0]  width_q;
	logic [semt_pkg::HEIGHT_W-1:0] height_q;
	logic [semt_pkg::THRESH_W-1:0] thresh_q;

	logic [AW-1:0] in_col_q, out_col_q;
	logic [RW-1:0] in_row_q, out_row_q;
	logic [PW-1:0] pending_q;
	logic          frame_done_q;
	logic [PX-1:0] win_q [9];

	logic [PX-1:0] px_s1;
	logic          border_q, last_q;
	logic signed [semt_pkg::GRAD_W-1:0] gx_s2, gy_s2;
	logic          sat_q;
	logic [semt_pkg::RAD_W-1:0] rad_q;
	logic [semt_pkg::REM_W-1:0] rem_q;
	logic [PX-1:0] root_q;
	logic [2:0]    step_q;

	logic          m_valid_q;
	logic [PX-1:0] mag_q;
	logic          edge_q, flast_q;

	// effective geometry
	logic [CW-1:0] width_ext;
	logic [WW-1:0] w_eff;
	logic [RW-1:0] h_eff;

	assign width_ext = CW'(width_q);
	always_comb begin
		if (width_q == '0) begin
			w_eff = WW'(1);
		end else if (width_ext > CW'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(width_ext);
		end
		h_eff = (height_q == '0) ? RW'(1) : RW'(height_q);
	end

	// counter advance
	logic [WW:0] in_col_inc, out_col_inc;
	logic [RW:0] in_row_inc, out_row_inc;
	logic        in_col_wrap, in_row_wrap, out_col_wrap, out_row_wrap;

	assign in_col_inc   = (WW+1)'(in_col_q) + (WW+1)'(1);
	assign out_col_inc  = (WW+1)'(out_col_q) + (WW+1)'(1);
	assign in_row_inc   = {1'b0, in_row_q} + (RW+1)'(1);
	assign out_row_inc  = {1'b0, out_row_q} + (RW+1)'(1);
	assign in_col_wrap  = in_col_inc >= {1'b0, w_eff};
	assign out_col_wrap = out_col_inc >= {1'b0, w_eff};
	assign in_row_wrap  = in_row_inc >= {1'b0, h_eff};
	assign out_row_wrap = out_row_inc >= {1'b0, h_eff};

	// border and last flags of the output position
	logic border_d, last_d;
	assign border_d = (out_row_q == '0) || (out_row_q >= h_eff - RW'(1)) ||
	                  (out_col_q == '0) || (WW'(out_col_q) >= w_eff - WW'(1));
	assign last_d   = (out_row_q == h_eff - RW'(1)) && (WW'(out_col_q) == w_eff - WW'(1));

	// handshake and control
	logic s_accept, is_pixel, flush_emit, pix_emit, emit_go, out_free;
	logic ram_re, ram_we;

	assign s_accept   = s_axis_tvalid && s_axis_tready;
	assign is_pixel   = (s_axis_tuser == semt_pkg::OP_PIXEL);
	assign flush_emit = frame_done_q && (pending_q != '0);
	assign pix_emit   = pending_q >= (PW'(w_eff) + PW'(1));
	assign out_free   = !m_valid_q || m_axis_tready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			semt_pkg::ST_IDLE: begin
				if (s_accept) begin
					if (is_pixel) begin
						state_d = semt_pkg::ST_RD;
					end else if (flush_emit) begin
						state_d = semt_pkg::ST_GRAD;
					end
				end
			end
			semt_pkg::ST_RD: begin
				state_d = pix_emit ? semt_pkg::ST_GRAD : semt_pkg::ST_IDLE;
			end
			semt_pkg::ST_GRAD: state_d = semt_pkg::ST_SQ;
			semt_pkg::ST_SQ:   state_d = semt_pkg::ST_ROOT;
			semt_pkg::ST_ROOT: begin
				if (step_q == '0) begin
					state_d = semt_pkg::ST_OUT;
				end
			end
			semt_pkg::ST_OUT: begin
				if (out_free) begin
					state_d = semt_pkg::ST_IDLE;
				end
			end
			default: state_d = semt_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = (state_q == semt_pkg::ST_IDLE);
		ram_re        = s_accept && is_pixel;
		ram_we        = (state_q == semt_pkg::ST_RD);
		emit_go       = (s_accept && !is_pixel && flush_emit) ||
		                ((state_q == semt_pkg::ST_RD) && pix_emit);
	end

	// row stores: [15:8] middle row, [7:0] upper row
	logic [2*PX-1:0] ram_rdata;
	logic [PX-1:0]   top_px, mid_px;

	assign top_px = ram_rdata[PX-1:0];
	assign mid_px = ram_rdata[2*PX-1:PX];

	semt_ram #(
		.WIDTH (2 * PX),
		.DEPTH (MAX_WIDTH)
	) u_rows (
		.clk   (clk),
		.we    (ram_we),
		.waddr (in_col_q),
		.wdata ({px_s1, mid_px}),
		.re    (ram_re),
		.raddr (in_col_q),
		.rdata (ram_rdata)
	);

	// gradients
	logic signed [semt_pkg::GRAD_W-1:0] p [9];
	logic signed [semt_pkg::GRAD_W-1:0] gx_d, gy_d;

	always_comb begin
		for (int i = 0; i < 9; i++) begin
			p[i] = $signed({3'b000, win_q[i]});
		end
		gx_d = p[2] - p[0] + p[5] + p[5] - p[3] - p[3] + p[8] - p[6];
		gy_d = p[6] - p[0] + p[7] + p[7] - p[1] - p[1] + p[8] - p[2];
	end

	// sum of squares
	logic signed [2*semt_pkg::GRAD_W-1:0] gx2, gy2;
	logic [semt_pkg::SQ_W-1:0] sq_d;

	always_comb begin
		gx2  = gx_s2 * gx_s2;
		gy2  = gy_s2 * gy_s2;
		sq_d = semt_pkg::SQ_W'(gx2) + semt_pkg::SQ_W'(gy2);
	end

	// one root bit per cycle
	logic [semt_pkg::REM_W+1:0] root_cur, root_trial, root_diff;
	logic                       root_ge;

	always_comb begin
		root_cur   = {rem_q, rad_q[semt_pkg::RAD_W-1 -: 2]};
		root_trial = {2'b00, root_q, 2'b01};
		root_ge    = root_cur >= root_trial;
		root_diff  = root_cur - root_trial;
	end

	logic [PX-1:0] mag_d;
	assign mag_d = border_q ? '0 : (sat_q ? {PX{1'b1}} : root_q);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= semt_pkg::ST_IDLE;
			width_q      <= semt_pkg::WIDTH_RST;
			height_q     <= semt_pkg::HEIGHT_RST;
			thresh_q     <= semt_pkg::THRESH_RST;
			in_col_q     <= '0;
			in_row_q     <= '0;
			out_col_q    <= '0;
			out_row_q    <= '0;
			pending_q    <= '0;
			frame_done_q <= 1'b0;
			step_q       <= '0;
			m_valid_q    <= 1'b0;
			for (int i = 0; i < 9; i++) begin
				win_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;

			if (cfg_we) begin
				unique case (cfg_idx)
					semt_pkg::REG_WIDTH:  width_q  <= cfg_data[semt_pkg::WIDTH_W-1:0];
					semt_pkg::REG_HEIGHT: height_q <= cfg_data[semt_pkg::HEIGHT_W-1:0];
					semt_pkg::REG_THRESH: thresh_q <= cfg_data[semt_pkg::THRESH_W-1:0];
					default: ;
				endcase
			end

			if (state_q == semt_pkg::ST_RD) begin
				for (int r = 0; r < 3; r++) begin
					win_q[r*3]   <= win_q[r*3+1];
					win_q[r*3+1] <= win_q[r*3+2];
				end
				win_q[2] <= top_px;
				win_q[5] <= mid_px;
				win_q[8] <= px_s1;

				frame_done_q <= 1'b0;
				if (in_col_wrap) begin
					in_col_q <= '0;
					if (in_row_wrap) begin
						in_row_q     <= '0;
						frame_done_q <= 1'b1;
					end else begin
						in_row_q <= in_row_inc[RW-1:0];
					end
				end else begin
					in_col_q <= in_col_inc[AW-1:0];
				end
				if (!pix_emit) begin
					pending_q <= pending_q + PW'(1);
				end
			end

			if (s_accept && !is_pixel && flush_emit) begin
				pending_q <= pending_q - PW'(1);
				if (pending_q == PW'(1)) begin
					frame_done_q <= 1'b0;
				end
			end

			if (emit_go) begin
				if (out_col_wrap) begin
					out_col_q <= '0;
					out_row_q <= out_row_wrap ? '0 : out_row_inc[RW-1:0];
				end else begin
					out_col_q <= out_col_inc[AW-1:0];
				end
			end

			if (state_q == semt_pkg::ST_SQ) begin
				step_q <= 3'd7;
			end else if (state_q == semt_pkg::ST_ROOT) begin
				step_q <= step_q - 3'd1;
			end

			if ((state_q == semt_pkg::ST_OUT) && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (s_accept) begin
			px_s1 <= s_axis_tdata;
		end
		if (emit_go) begin
			border_q <= border_d;
			last_q   <= last_d;
		end
		if (state_q == semt_pkg::ST_GRAD) begin
			gx_s2 <= gx_d;
			gy_s2 <= gy_d;
		end
		if (state_q == semt_pkg::ST_SQ) begin
			sat_q  <= |sq_d[semt_pkg::SQ_W-1:semt_pkg::RAD_W];
			rad_q  <= sq_d[semt_pkg::RAD_W-1:0];
			rem_q  <= '0;
			root_q <= '0;
		end else if (state_q == semt_pkg::ST_ROOT) begin
			rad_q  <= {rad_q[semt_pkg::RAD_W-3:0], 2'b00};
			rem_q  <= root_ge ? root_diff[semt_pkg::REM_W-1:0] :
			                    root_cur[semt_pkg::REM_W-1:0];
			root_q <= {root_q[PX-2:0], root_ge};
		end
		if ((state_q == semt_pkg::ST_OUT) && out_free) begin
			mag_q   <= mag_d;
			edge_q  <= mag_d > thresh_q;
			flast_q <= last_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {7'b0000000, edge_q, mag_q};
	assign m_axis_tlast  = flast_q;

	`SEMT_ASSERT_NEXT(a_pixel_reads_row, s_accept && is_pixel, state_q == semt_pkg::ST_RD, "pixel item did not go to row read")
	`SEMT_ASSERT_NOW(a_frame_done_col, frame_done_q, in_col_q == '0, "frame complete away from column zero")
	`SEMT_ASSERT_NOW(a_root_rem, state_q == semt_pkg::ST_OUT, {1'b0, rem_q} <= {2'b00, root_q, 1'b0}, "root remainder out of range")
	`SEMT_ASSERT_NEXT(a_out_wait, (state_q == semt_pkg::ST_OUT) && m_valid_q && !m_axis_tready, state_q == semt_pkg::ST_OUT, "result overwrote a waiting item")

endmodule

/* hw/rtl/semt_ram.sv */
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module semt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* bench/tb.sv */
// Self-checking bench for sobel_edge_magnitude_threshold: raster frames in, edge pixels out.
// Holds its own row-store and window tracker that predicts each output item.
// Depends on semt_pkg and the sobel_edge_magnitude_threshold RTL.
`timescale 1ns / 1ps

module tb;

	localparam int ROW_DEPTH     = 2048;
	localparam int SETTLE_CYCLES = 30;
	localparam int RANDOM_ITEMS  = 1650;

	typedef struct packed {
		logic [0:0]                 op;
		logic [semt_pkg::PIX_W-1:0] pixel;
	} raster_item_t;

	typedef struct packed {
		logic [semt_pkg::PIX_W-1:0] magnitude;
		logic                       edge_res;
		logic                       frame_last;
	} edge_px_t;

	typedef enum int {
		FILL_NOISE,
		FILL_BINARY,
		FILL_RAMP
	} fill_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_idx = semt_pkg::REG_WIDTH;
	logic [15:0] cfg_data = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;    // [7:0] pixel
	logic [0:0]  s_axis_tuser = semt_pkg::OP_PIXEL; // [0] op
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;         // [7:0] magnitude, [8] edge_res, [15:9] zero
	logic        m_axis_tlast;

	sobel_edge_magnitude_threshold u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_idx       (cfg_idx),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Tracker state: geometry, row stores, window and raster counters
	logic [semt_pkg::WIDTH_W-1:0]  trk_width  = semt_pkg::WIDTH_RST;
	logic [semt_pkg::HEIGHT_W-1:0] trk_height = semt_pkg::HEIGHT_RST;
	logic [semt_pkg::THRESH_W-1:0] trk_thresh = semt_pkg::THRESH_RST;
	logic [7:0]          row_above [ROW_DEPTH];
	logic [7:0]          row_mid   [ROW_DEPTH];
	logic [7:0]          win       [9];
	int                  in_col, in_row, out_col, out_row, pend_cnt;
	bit                  frame_done;

	raster_item_t raster_q[$];
	edge_px_t     edge_px_q[$];
	int           mismatches = 0;

	function automatic int eff_width();
		if (trk_width == 0) return 1;
		if (trk_width > ROW_DEPTH) return ROW_DEPTH;
		return int'(trk_width);
	endfunction

	function automatic int eff_height();
		return (trk_height == 0) ? 1 : int'(trk_height);
	endfunction

	task automatic emit_pixel(input int w, input int h);
		edge_px_t px;
		int       gx, gy, sq, root;
		bit       border;
		border = out_row == 0 || out_row >= h - 1 || out_col == 0 || out_col >= w - 1;
		root = 0;
		if (!border) begin
			gx = -int'(win[0]) + int'(win[2]) - 2 * int'(win[3]) + 2 * int'(win[5])
				- int'(win[6]) + int'(win[8]);
			gy = -int'(win[0]) - 2 * int'(win[1]) - int'(win[2])
				+ int'(win[6]) + 2 * int'(win[7]) + int'(win[8]);
			sq = gx * gx + gy * gy;
			if (sq >= 65536) begin
				root = 255;
			end else begin
				for (int b = 7; b >= 0; b--)
					if ((root | (1 << b)) * (root | (1 << b)) <= sq) root |= 1 << b;
			end
		end
		px.magnitude  = 8'(root);
		px.edge_res   = root > int'(trk_thresh);
		px.frame_last = out_row == h - 1 && out_col == w - 1;
		edge_px_q.push_back(px);
		if (out_col + 1 >= w) begin
			out_col = 0;
			out_row = (out_row + 1 >= h) ? 0 : out_row + 1;
		end else begin
			out_col++;
		end
	endtask

	task automatic advance_sobel(input logic [0:0] op, input logic [7:0] pix);
		int         w, h, col;
		logic [7:0] top, mid;
		w = eff_width();
		h = eff_height();
		if (op == semt_pkg::OP_FLUSH) begin
			if (frame_done && pend_cnt > 0) begin
				emit_pixel(w, h);
				pend_cnt--;
				if (pend_cnt == 0) frame_done = 1'b0;
			end
		end else begin
			col = (in_col < ROW_DEPTH) ? in_col : 0;
			top = row_above[col];
			mid = row_mid[col];
			for (int r = 0; r < 3; r++) begin
				win[r * 3]     = win[r * 3 + 1];
				win[r * 3 + 1] = win[r * 3 + 2];
			end
			win[2] = top;
			win[5] = mid;
			win[8] = pix;
			row_above[col] = mid;
			row_mid[col]   = pix;
			frame_done = 1'b0;
			if (in_col + 1 >= w) begin
				in_col = 0;
				if (in_row + 1 >= h) begin
					in_row = 0;
					frame_done = 1'b1;
				end else begin
					in_row++;
				end
			end else begin
				in_col++;
			end
			pend_cnt++;
			if (pend_cnt > w + 1) begin
				emit_pixel(w, h);
				pend_cnt--;
			end
		end
	endtask

	initial begin
		for (int i = 0; i < ROW_DEPTH; i++) begin
			row_above[i] = '0;
			row_mid[i]   = '0;
		end
		for (int i = 0; i < 9; i++) win[i] = '0;
		in_col = 0;
		in_row = 0;
		out_col = 0;
		out_row = 0;
		pend_cnt = 0;
		frame_done = 1'b0;
	end

	// Sender: bursts of random length, random gaps between them
	raster_item_t tx_next;
	int           tx_burst = 1;
	int           tx_gap = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) advance_sobel(s_axis_tuser, s_axis_tdata);
			if (!s_axis_tvalid || s_axis_tready) begin
				if (tx_gap > 0) begin
					tx_gap <= tx_gap - 1;
					s_axis_tvalid <= 1'b0;
				end else if (raster_q.size() > 0) begin
					tx_next = raster_q.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= tx_next.pixel;
					s_axis_tuser  <= tx_next.op;
					if (tx_burst <= 1) begin
						tx_burst <= $urandom_range(1, 40);
						tx_gap   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
					end else begin
						tx_burst <= tx_burst - 1;
					end
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: stall pattern switches between always ready, coin flips and long stalls
	int rx_mode = 0;
	int rx_mode_left = 0;
	int rx_stall = 0;

	always @(posedge clk) begin
		if (rx_mode_left == 0) begin
			rx_mode      <= $urandom_range(0, 2);
			rx_mode_left <= $urandom_range(20, 200);
		end else begin
			rx_mode_left <= rx_mode_left - 1;
		end
		if (rx_stall > 0) begin
			rx_stall <= rx_stall - 1;
			m_axis_tready <= 1'b0;
		end else begin
			case (rx_mode)
				0: begin
					m_axis_tready <= 1'b1;
				end
				1: begin
					m_axis_tready <= $urandom_range(0, 1);
				end
				default: begin
					if ($urandom_range(0, 9) == 0) begin
						rx_stall <= $urandom_range(1, 16);
						m_axis_tready <= 1'b0;
					end else begin
						m_axis_tready <= 1'b1;
					end
				end
			endcase
		end
	end

	edge_px_t rx_want;

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (edge_px_q.size() == 0) begin
				$error("unexpected item: magnitude %0d edge_res %0d frame_last %0d",
					m_axis_tdata[7:0], m_axis_tdata[8], m_axis_tlast);
				mismatches++;
			end else begin
				rx_want = edge_px_q.pop_front();
				if (m_axis_tdata[7:0] !== rx_want.magnitude) begin
					$error("magnitude: expected %0d, got %0d", rx_want.magnitude,
						m_axis_tdata[7:0]);
					mismatches++;
				end
				if (m_axis_tdata[8] !== rx_want.edge_res) begin
					$error("edge_res: expected %0d, got %0d", rx_want.edge_res, m_axis_tdata[8]);
					mismatches++;
				end
				if (m_axis_tlast !== rx_want.frame_last) begin
					$error("frame_last: expected %0d, got %0d", rx_want.frame_last, m_axis_tlast);
					mismatches++;
				end
				if (m_axis_tdata[15:9] !== 7'd0) begin
					$error("tdata padding: expected 0, got %0d", m_axis_tdata[15:9]);
					mismatches++;
				end
			end
		end
	end

	// Stimulus side: its own view of geometry and of outputs still owed
	int gen_w, gen_h, gen_pend, counted;
	bit gen_done;

	task automatic write_cfg(input logic [1:0] idx, input logic [15:0] val);
		@(posedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			semt_pkg::REG_WIDTH:  trk_width  = val[semt_pkg::WIDTH_W-1:0];
			semt_pkg::REG_HEIGHT: trk_height = val[semt_pkg::HEIGHT_W-1:0];
			semt_pkg::REG_THRESH: trk_thresh = val[semt_pkg::THRESH_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_geometry(input int w, input int h, input int thr);
		write_cfg(semt_pkg::REG_WIDTH, 16'(w));
		write_cfg(semt_pkg::REG_HEIGHT, 16'(h));
		write_cfg(semt_pkg::REG_THRESH, 16'(thr));
		gen_w = eff_width();
		gen_h = eff_height();
	endtask

	task automatic push_pixel(input logic [7:0] v, input bit frame_end);
		raster_q.push_back('{op: semt_pkg::OP_PIXEL, pixel: v});
		gen_done = frame_end;
		gen_pend++;
		if (gen_pend > gen_w + 1) gen_pend--;
		counted++;
	endtask

	task automatic push_flush();
		raster_q.push_back('{op: semt_pkg::OP_FLUSH, pixel: 8'($urandom)});
		if (gen_done && gen_pend > 0) begin
			gen_pend--;
			counted++;
			if (gen_pend == 0) gen_done = 1'b0;
		end
	endtask

	// sampled away from the driving edge so a just-popped item shows as valid
	task automatic drain_all();
		do @(negedge clk);
		while (raster_q.size() != 0 || s_axis_tvalid || edge_px_q.size() != 0);
	endtask

	task automatic settle();
		drain_all();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send_frame(input fill_t style, input bit noisy, input int pause_at);
		int         total, r, c, base, slope;
		logic [7:0] v;
		total = gen_w * gen_h;
		base  = $urandom_range(0, 255);
		slope = $urandom_range(0, 40);
		for (int i = 0; i < total; i++) begin
			r = i / gen_w;
			c = i % gen_w;
			case (style)
				FILL_BINARY: v = $urandom_range(0, 1) ? 8'hFF : 8'h00;
				FILL_RAMP:   v = 8'(base + slope * c + 3 * r + $urandom_range(0, 3));
				default:     v = 8'($urandom);
			endcase
			push_pixel(v, i == total - 1);
			if (noisy && i < total - 1 && $urandom_range(0, 24) == 0) push_flush();
			if (i == pause_at) drain_all();
		end
	endtask

	task automatic flush_pending(input int n);
		repeat (n) push_flush();
	endtask

	initial begin
		logic [7:0] shape_a [9];
		logic [7:0] shape_b [9];
		int         wsel, hsel, tsel, w, h, thr, nframes, pause_frame, target, cut;
		shape_a = '{8'd0, 8'd0, 8'd255, 8'd0, 8'd128, 8'd255, 8'd0, 8'd0, 8'd255};
		shape_b = '{8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255};
		gen_pend = 0;
		gen_done = 1'b0;
		counted = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// 3x3 frames: saturating gradient, flat ring, stray flushes, seamless next frame
		set_geometry(3, 3, 0);
		push_flush();
		for (int i = 0; i < 9; i++) begin
			push_pixel(shape_a[i], i == 8);
			if (i == 4) push_flush();
		end
		for (int i = 0; i < 9; i++) push_pixel(shape_b[i], i == 8);
		flush_pending(gen_pend);
		push_flush();
		settle();

		target = counted + RANDOM_ITEMS;
		while (counted < target) begin
			wsel = $urandom_range(0, 19);
			hsel = $urandom_range(0, 9);
			tsel = $urandom_range(0, 5);
			if (wsel == 0) w = 0;
			else if (wsel == 1) w = 1;
			else if (wsel == 2) w = 2;
			else if (wsel < 5) w = $urandom_range(11, 40);
			else w = $urandom_range(3, 10);
			if (hsel == 0) h = 0;
			else if (hsel == 1) h = $urandom_range(7, 12);
			else h = $urandom_range(1, 6);
			if (tsel == 0) thr = 0;
			else if (tsel == 1) thr = 255;
			else thr = $urandom_range(0, 255);
			set_geometry(w, h, thr);
			nframes = $urandom_range(1, 3);
			pause_frame = $urandom_range(0, 3);
			for (int f = 0; f < nframes; f++) begin
				send_frame(fill_t'($urandom_range(0, 2)), $urandom_range(0, 3) == 0,
					(f == pause_frame) ? $urandom_range(0, gen_w * gen_h - 1) : -1);
				if (f == nframes - 1) begin
					flush_pending(gen_pend);
					if ($urandom_range(0, 3) == 0) push_flush();
				end else if ($urandom_range(0, 1) == 0) begin
					cut = $urandom_range(0, gen_pend);
					flush_pending(cut);
				end
			end
			settle();
		end

		// tallest frame, left unfinished: results come only as the window moves on
		set_geometry(5, 65535, $urandom_range(0, 255));
		for (int i = 0; i < 150; i++) begin
			push_pixel(8'($urandom), 1'b0);
			if (i == 70) push_flush();
		end
		settle();

		if (mismatches == 0 && edge_px_q.size() == 0) begin
			$display("sobel_edge_magnitude_threshold verification clean");
		end else begin
			$display("sobel_edge_magnitude_threshold verification failed");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("sobel_edge_magnitude_threshold verification failed");
		$finish;
	end

endmodule
